[hdl/fqs_pkg.sv]
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared types and constants for the FIFO queue with linear search.
// ----------------------------------------------------------------------------
package fqs_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int CMD_W   = 2;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int CNT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUSH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    cmd_t op;         // its command
    logic scan_step;  // search scan in progress
    logic load_out;   // move result into output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic scan_done;
  } dp_stat_t;

endpackage

[hdl/fifo_queue_with_search.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// FIFO queue of signed values in a ring RAM, with a linear search command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_command selects insert, remove head,
//   search or clear; in_value is the value to insert or search for.
//   Output channel (out_valid/out_ready): one result transaction per command
//   with success, found, position (from head) and the count after the command.
// Timing:
//   One command is in flight at a time; in_ready is high when the controller
//   is idle, even while the previous result still waits in the output register.
//   Insert, remove and clear: the result is registered in the result registers,
//   then loaded into the output register in the push state before idle.
//   Search: scan reads one RAM entry per cycle through the registered read
//   port; a hit ends the scan early. An empty-queue search skips the scan and
//   goes straight to the push state.
// Reset (rst_n, synchronous, active low): queue empty, pointers zero, no
//   result pending. RAM contents are not cleared; only live entries are read.
// Stall: if out_ready is low the result holds in the output register and the
//   controller waits in its push state before taking another command.
// ----------------------------------------------------------------------------
module fifo_queue_with_search #(
  parameter int DEPTH      = fqs_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = fqs_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [fqs_pkg::CMD_W-1:0]          in_command,
  input  logic signed [fqs_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_success,
  output logic                               out_found,
  output logic [fqs_pkg::POS_W-1:0]          out_position,
  output logic [fqs_pkg::CNT_W-1:0]          out_count
);
  import fqs_pkg::*;

  ctrl_cmd_t cmd;   // controller commands to datapath
  dp_stat_t  stat;  // datapath status: empty, scan finished

  // Controller: handshake and sequencing only.
  fqs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: ring pointers, entry RAM, pipelined compare, result registers.
  fqs_dp #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_value     (in_value),
    .stat         (stat),
    .out_success  (out_success),
    .out_found    (out_found),
    .out_position (out_position),
    .out_count    (out_count)
  );

endmodule

[hdl/fqs_ram.sv]
// ----------------------------------------------------------------------------
// fqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/fqs_dp.sv]
// ----------------------------------------------------------------------------
// fqs_dp
// Queue datapath: ring pointers, entry RAM, search scan and result registers.
// ----------------------------------------------------------------------------
module fqs_dp #(
  parameter int DEPTH      = fqs_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = fqs_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fqs_pkg::ctrl_cmd_t                 cmd,
  input  logic signed [fqs_pkg::VALUE_W-1:0] in_value,
  output fqs_pkg::dp_stat_t                  stat,
  output logic                               out_success,
  output logic                               out_found,
  output logic [fqs_pkg::POS_W-1:0]          out_position,
  output logic [fqs_pkg::CNT_W-1:0]          out_count
);
  import fqs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] p);
    next_idx = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  logic [AW-1:0]         head_r, head_nxt;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]         issue_cnt_r, issue_cnt_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic                  res_success_r, res_success_nxt;
  logic                  res_found_r, res_found_nxt;
  logic [POS_W-1:0]      res_pos_r, res_pos_nxt;
  logic                  out_success_r;
  logic                  out_found_r;
  logic [POS_W-1:0]      out_position_r;
  logic [CNT_W-1:0]      out_count_r;

  logic signed [63:0]    val_sx;
  logic [VALUE_BITS-1:0] val_in;
  logic [VALUE_BITS-1:0] rd_data;
  logic                  ram_we;
  logic                  full;
  logic                  hit;
  logic                  last;
  logic [31:0]           cmp_idx_wide;
  logic [31:0]           count_wide;

  // sign-extend then keep the stored width
  assign val_sx = 64'(in_value);
  assign val_in = val_sx[VALUE_BITS-1:0];

  assign full   = (count_r == FULL_CNT);
  assign ram_we = cmd.accept && (cmd.op == CMD_INSERT) && !full;

  fqs_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (val_in),
    .raddr (rd_ptr_r),
    .rdata (rd_data)
  );

  // compare stage sees RAM data for entry cmp_idx_r
  assign hit          = cmp_vld_r && (rd_data == key_r);
  assign last         = cmp_vld_r && ((CW'(cmp_idx_r) + CW'(1)) == count_r);
  assign cmp_idx_wide = 32'(cmp_idx_r);
  assign count_wide   = 32'(count_r);

  assign stat.empty     = (count_r == '0);
  assign stat.scan_done = hit || last;

  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    rd_ptr_nxt      = rd_ptr_r;
    issue_cnt_nxt   = issue_cnt_r;
    cmp_vld_nxt     = cmp_vld_r;
    cmp_idx_nxt     = cmp_idx_r;
    key_nxt         = key_r;
    res_success_nxt = res_success_r;
    res_found_nxt   = res_found_r;
    res_pos_nxt     = res_pos_r;

    if (cmd.accept) begin
      res_success_nxt = 1'b1;
      res_found_nxt   = 1'b0;
      res_pos_nxt     = '0;
      case (cmd.op)
        CMD_INSERT: begin
          if (full) begin
            res_success_nxt = 1'b0;
          end else begin
            tail_nxt  = next_idx(tail_r);
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (count_r == '0) begin
            res_success_nxt = 1'b0;
          end else begin
            head_nxt  = next_idx(head_r);
            count_nxt = count_r - 1'b1;
          end
        end
        CMD_SEARCH: begin
          key_nxt       = val_in;
          rd_ptr_nxt    = head_r;
          issue_cnt_nxt = '0;
          cmp_vld_nxt   = 1'b0;
        end
        CMD_CLEAR: begin
          head_nxt  = '0;
          tail_nxt  = '0;
          count_nxt = '0;
        end
        default: begin
          res_success_nxt = 1'b1;
        end
      endcase
    end else if (cmd.scan_step) begin
      // issue next read while comparing the previous one
      if (issue_cnt_r < count_r) begin
        rd_ptr_nxt    = next_idx(rd_ptr_r);
        issue_cnt_nxt = issue_cnt_r + 1'b1;
        cmp_vld_nxt   = 1'b1;
        cmp_idx_nxt   = issue_cnt_r[AW-1:0];
      end else begin
        cmp_vld_nxt = 1'b0;
      end
      if (hit) begin
        res_found_nxt = 1'b1;
        res_pos_nxt   = cmp_idx_wide[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r      <= rd_ptr_nxt;
    issue_cnt_r   <= issue_cnt_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    key_r         <= key_nxt;
    res_success_r <= res_success_nxt;
    res_found_r   <= res_found_nxt;
    res_pos_r     <= res_pos_nxt;
    if (cmd.load_out) begin
      out_success_r  <= res_success_r;
      out_found_r    <= res_found_r;
      out_position_r <= res_pos_r;
      out_count_r    <= count_wide[CNT_W-1:0];
    end
  end

  assign out_success  = out_success_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;
  assign out_count    = out_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> issue_cnt_r <= count_r)
    else $error("scan issued past live entries");
`endif

endmodule

[hdl/fqs_ctrl.sv]
// ----------------------------------------------------------------------------
// fqs_ctrl
// Controller FSM: input handshake, search scan sequencing, output valid.
// ----------------------------------------------------------------------------
module fqs_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fqs_pkg::CMD_W-1:0]     in_command,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  fqs_pkg::dp_stat_t             stat,
  output fqs_pkg::ctrl_cmd_t            cmd
);
  import fqs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.accept    = accept;
    cmd.op        = cmd_t'(in_command);
    cmd.scan_step = 1'b0;
    cmd.load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((cmd_t'(in_command) == CMD_SEARCH) && !stat.empty) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten before taken");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second transaction taken while one in flight");

  a_valid_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_PUSH))
    else $error("result presented without push");
`endif

endmodule

[dv/tb_fifo_queue_with_search.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fifo_queue_with_search
// Self-checking bench for the FIFO queue with linear search. A mirror of the
// ring (head, tail, fill and stored values) predicts every result; each
// result transaction is matched field by field against the oldest
// prediction. A short directed run covers the edge cases, then random
// command mixes run with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_fifo_queue_with_search;
  import fqs_pkg::*;

  localparam int QDEPTH     = DEPTH_DEF;
  localparam int IDLE_LIMIT = 3000;   // cycles with no transaction at all
  localparam int HOLD_LEN   = 400;    // long receiver hold-off
  localparam int DRAIN_WAIT = 30;     // quiet cycles after the last result
  localparam int SEGMENTS   = 25;
  localparam int SEG_ITEMS  = 49;
  localparam int MAX_REPORTS = 100;

  typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } mix_t;

  typedef struct packed {
    logic             success;
    logic             found;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count;
  } queue_result_t;

  // --------------------------------------------------------------------------
  // Mirror of the queue plus the list of results still owed by the block.
  // VALUE_BITS is 32, so values are stored and compared whole.
  // --------------------------------------------------------------------------
  class queue_checker;
    logic [VALUE_W-1:0] slots[QDEPTH];
    int                 head;
    int                 tail;
    int                 fill;
    queue_result_t      owed[$];
    int                 errors;

    function new();
      head   = 0;
      tail   = 0;
      fill   = 0;
      errors = 0;
    endfunction

    // Predict the result of one accepted command transaction.
    function void note_command(cmd_t op, logic [VALUE_W-1:0] v);
      queue_result_t r;
      int            idx;
      int            k;
      logic          hit;
      r   = '0;
      r.success = 1'b1;
      hit = 1'b0;
      case (op)
        CMD_INSERT: begin
          if (fill == QDEPTH) begin
            r.success = 1'b0;          // full: refused, nothing moves
          end else begin
            slots[tail] = v;
            tail = (tail + 1) % QDEPTH;
            fill++;
          end
        end
        CMD_REMOVE: begin
          if (fill == 0) begin
            r.success = 1'b0;          // empty: refused
          end else begin
            head = (head + 1) % QDEPTH;
            fill--;
          end
        end
        CMD_SEARCH: begin
          // only live entries are scanned, oldest first
          idx = head;
          for (k = 0; k < fill && !hit; k++) begin
            if (slots[idx] == v) begin
              hit        = 1'b1;
              r.found    = 1'b1;
              r.position = k[POS_W-1:0];
            end
            idx = (idx + 1) % QDEPTH;
          end
        end
        default: begin
          head = 0;
          tail = 0;
          fill = 0;
        end
      endcase
      r.count = fill[CNT_W-1:0];
      owed.push_back(r);
    endfunction

    function void report_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        if (errors < MAX_REPORTS)
          $display("%0t ERROR %s expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one result transaction with the oldest prediction.
    function void check_result(queue_result_t got);
      queue_result_t want;
      if (owed.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t ERROR unexpected result expected none actual %0d/%0d/%0d/%0d",
                   $time, got.success, got.found, got.position, got.count);
        errors++;
        return;
      end
      want = owed.pop_front();
      report_field("success",  want.success,  got.success);
      report_field("found",    want.found,    got.found);
      report_field("position", want.position, got.position);
      report_field("count",    want.count,    got.count);
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command   = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic                out_success;
  logic                out_found;
  logic [POS_W-1:0]    out_position;
  logic [CNT_W-1:0]    out_count;

  // stimulus -> receiver process controls
  logic                calm_mode    = 1'b0;  // no idling on either side
  logic                hold_req     = 1'b0;  // ask for the long hold-off

  queue_checker        book;
  int                  idle_cycles  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  fifo_queue_with_search #(
    .DEPTH      (QDEPTH),
    .VALUE_BITS (VALUE_BITS_DEF)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_success  (out_success),
    .out_found    (out_found),
    .out_position (out_position),
    .out_count    (out_count)
  );

  // --------------------------------------------------------------------------
  // Random idle lengths: mostly short, a few long
  // --------------------------------------------------------------------------
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int next_gap(logic calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  function automatic cmd_t pick_command(mix_t m);
    int unsigned r;
    int unsigned ins_w;
    int unsigned rem_w;
    r = $urandom_range(0, 99);
    case (m)
      MIX_FILL:  begin ins_w = 60; rem_w = 8;  end
      MIX_DRAIN: begin ins_w = 20; rem_w = 50; end
      default:   begin ins_w = 40; rem_w = 25; end
    endcase
    if (r < ins_w) return CMD_INSERT;
    if (r < ins_w + rem_w) return CMD_REMOVE;
    if (r < 98) return CMD_SEARCH;
    return CMD_CLEAR;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: idle for gap cycles, present the transaction, hold it until taken.
  // With gap 0 valid simply stays high into the next transaction, so valid
  // never sees two assignments in the same step.
  // --------------------------------------------------------------------------
  task automatic send_command(cmd_t op, logic [VALUE_W-1:0] v, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= op;
    in_value   <= v;
    do @(posedge clk); while (!in_ready);
    book.note_command(op, v);
  endtask

  // Edge cases: empty queue, value extremes, filling up, full refusal,
  // first of duplicates, match at the far end, clear.
  task automatic run_directed();
    logic [VALUE_W-1:0] v;
    send_command(CMD_SEARCH, 32'h0000_0000, next_gap(1'b0));   // search empty
    send_command(CMD_REMOVE, 32'hffff_ffff, next_gap(1'b0));   // remove empty
    for (int i = 0; i < QDEPTH; i++) begin
      case (i)
        0:       v = 32'h8000_0000;
        1:       v = 32'h7fff_ffff;
        2:       v = 32'h0000_0000;
        3, 4:    v = 32'hffff_ffff;                 // duplicate pair
        QDEPTH-1: v = 32'h1357_9bdf;                // unique last entry
        default: v = {8'($urandom_range(0, 255)), 24'h00_0000} | 32'h0000_0001;
      endcase
      send_command(CMD_INSERT, v, next_gap(1'b0));
    end
    send_command(CMD_INSERT, 32'h5555_aaaa, next_gap(1'b0));   // full refusal
    send_command(CMD_SEARCH, 32'hffff_ffff, next_gap(1'b0));   // first duplicate
    send_command(CMD_SEARCH, 32'h1357_9bdf, next_gap(1'b0));   // last position
    send_command(CMD_REMOVE, 32'h0000_0000, next_gap(1'b0));
    send_command(CMD_CLEAR,  32'haaaa_5555, next_gap(1'b0));
    send_command(CMD_SEARCH, 32'h7fff_ffff, next_gap(1'b0));   // after clear
  endtask

  // --------------------------------------------------------------------------
  // Main stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [VALUE_W-1:0] pool[8];
    logic               seg_calm;
    mix_t               seg_mix;
    cmd_t               op;
    logic [VALUE_W-1:0] v;

    book = new();
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // A small value pool keeps searches hitting; fresh random values cover
    // misses and every bit of the value field.
    for (int s = 0; s < SEGMENTS; s++) begin
      seg_calm = ($urandom_range(0, 4) == 0);
      seg_mix  = mix_t'($urandom_range(0, 2));
      calm_mode <= seg_calm;
      if (s == 6) hold_req <= 1'b1;   // long receiver hold-off starts here
      pool[$urandom_range(2, 7)] = $urandom;
      for (int i = 0; i < SEG_ITEMS; i++) begin
        op = pick_command(seg_mix);
        if ($urandom_range(0, 3) != 0) v = pool[$urandom_range(0, 7)];
        else                           v = $urandom;
        send_command(op, v, next_gap(seg_calm));
      end
    end
    in_valid <= 1'b0;

    // Let the last results drain, then a few quiet cycles for strays.
    while (book.pending() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (book.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, calm stretches, and one long hold-off counted
  // here so the sender keeps offering while the block backs up.
  // --------------------------------------------------------------------------
  initial begin
    int   stall_left;
    int   hold_left;
    logic hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm_mode) begin
        stall_left = 0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = idle_len() - 1;
        out_ready <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: sampled at the edge, before any NBA of that step lands
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    queue_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.success  = out_success;
      got.found    = out_found;
      got.position = out_position;
      got.count    = out_count;
      book.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transaction on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ERROR timeout with %0d results outstanding", $time, book.pending());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
